// ===== rtl/assert_macros.svh =====
// Assertion helpers; the enclosing module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define QAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`define QAU_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/qau_pkg.sv =====
`default_nettype none
package qau_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;
    localparam int QN             = 4;
    localparam int FIFO_DEPTH     = 2;
    localparam int OP_BITS        = 2;

    typedef logic [OP_BITS-1:0] op_t;

    localparam op_t OP_MUL  = 2'd0;
    localparam op_t OP_CONJ = 2'd1;
    localparam op_t OP_LEN  = 2'd2;
    localparam op_t OP_NORM = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/qau_front.sv =====
`default_nettype none
`include "assert_macros.svh"
module qau_front
    import qau_pkg::*;
#(
    parameter int DW = DATA_WIDTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [8*DW+1:0]   in_data,
    output logic                   out_valid,
    input  wire logic              out_pop,
    output logic [8*DW+1:0]        out_data
);

    localparam int AW = $clog2(FIFO_DEPTH);

    logic [8*DW+1:0] mem [FIFO_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            push, pop;

    assign in_ready  = (count_reg != AW'(0) + (AW+1)'(FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (AW+1)'(1);
            2'b01:   count_next = count_reg - (AW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_data;
    end

    `QAU_ASSERT(a_count_bound, count_reg <= (AW+1)'(FIFO_DEPTH), "queue count past depth")
    `QAU_ASSERT(a_count_up, push && !pop |=> count_reg == $past(count_reg) + (AW+1)'(1), "queue count did not rise")
    `QAU_ASSERT_NEVER(a_ptr_sync, count_reg == '0 && wr_ptr_reg != rd_ptr_reg, "empty queue with split pointers")

endmodule
`default_nettype wire

// ===== rtl/qau_sqrt.sv =====
`default_nettype none
module qau_sqrt
    import qau_pkg::*;
#(
    parameter int RW = DATA_WIDTH_DEF + 1,
    parameter int TW = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [2*RW-1:0]   n_in,
    input  wire logic [TW-1:0]     tag_in,
    output logic                   out_valid,
    output logic [RW-1:0]          root,
    output logic [RW+1:0]          rem,
    output logic [TW-1:0]          tag_out
);

    // one root bit per stage, restoring digit recurrence
    logic [RW-1:0]   root_reg [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [2*RW-1:0] n_reg    [RW];
    logic [TW-1:0]   tag_reg  [RW];
    logic [RW-1:0]   v_reg;

    for (genvar i = 0; i < RW; i++)
    begin : g_st
        logic [RW-1:0]   root_p;
        logic [RW+1:0]   rem_p;
        logic [2*RW-1:0] n_p;
        logic [TW-1:0]   tag_p;
        logic            v_p;
        logic [RW+3:0]   acc, trial, diff;
        logic            ge;

        if (i == 0)
        begin : g_first
            assign root_p = '0;
            assign rem_p  = '0;
            assign n_p    = n_in;
            assign tag_p  = tag_in;
            assign v_p    = in_valid;
        end
        else
        begin : g_next
            assign root_p = root_reg[i-1];
            assign rem_p  = rem_reg[i-1];
            assign n_p    = n_reg[i-1];
            assign tag_p  = tag_reg[i-1];
            assign v_p    = v_reg[i-1];
        end

        assign acc   = {rem_p, n_p[2*RW-1 -: 2]};
        assign trial = {2'b00, root_p, 2'b01};
        assign diff  = acc - trial;
        assign ge    = (acc >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= v_p;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[i] <= {root_p[RW-2:0], ge};
                rem_reg[i]  <= ge ? diff[RW+1:0] : acc[RW+1:0];
                n_reg[i]    <= n_p << 2;
                tag_reg[i]  <= tag_p;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign rem       = rem_reg[RW-1];
    assign tag_out   = tag_reg[RW-1];

endmodule
`default_nettype wire

// ===== rtl/qau_div.sv =====
`default_nettype none
module qau_div
    import qau_pkg::*;
#(
    parameter int NW = DATA_WIDTH_DEF + FRAC_BITS_DEF,
    parameter int LW = DATA_WIDTH_DEF + 2,
    parameter int TW = 1
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [QN-1:0][NW-1:0] num,
    input  wire logic [LW-1:0]         den,
    input  wire logic [TW-1:0]         tag_in,
    output logic                       out_valid,
    output logic [QN-1:0][NW-1:0]      quo,
    output logic [LW-1:0]              den_out,
    output logic [TW-1:0]              tag_out
);

    // one quotient bit per stage for all four lanes, shared divisor
    logic [QN-1:0][NW-1:0] n_reg   [NW];
    logic [QN-1:0][NW-1:0] q_reg   [NW];
    logic [QN-1:0][LW-1:0] rem_reg [NW];
    logic [LW-1:0]         den_reg [NW];
    logic [TW-1:0]         tag_reg [NW];
    logic [NW-1:0]         v_reg;

    for (genvar i = 0; i < NW; i++)
    begin : g_st
        logic [QN-1:0][NW-1:0] n_p, q_p;
        logic [QN-1:0][LW-1:0] rem_p;
        logic [LW-1:0]         den_p;
        logic [TW-1:0]         tag_p;
        logic                  v_p;
        logic [QN-1:0][NW-1:0] n_nx, q_nx;
        logic [QN-1:0][LW-1:0] rem_nx;

        if (i == 0)
        begin : g_first
            assign n_p   = num;
            assign q_p   = '0;
            assign rem_p = '0;
            assign den_p = den;
            assign tag_p = tag_in;
            assign v_p   = in_valid;
        end
        else
        begin : g_next
            assign n_p   = n_reg[i-1];
            assign q_p   = q_reg[i-1];
            assign rem_p = rem_reg[i-1];
            assign den_p = den_reg[i-1];
            assign tag_p = tag_reg[i-1];
            assign v_p   = v_reg[i-1];
        end

        for (genvar l = 0; l < QN; l++)
        begin : g_lane
            logic [LW:0] acc, diff;
            logic        ge;
            assign acc       = {rem_p[l], n_p[l][NW-1]};
            assign diff      = acc - {1'b0, den_p};
            assign ge        = (acc >= {1'b0, den_p});
            assign rem_nx[l] = ge ? diff[LW-1:0] : acc[LW-1:0];
            assign q_nx[l]   = {q_p[l][NW-2:0], ge};
            assign n_nx[l]   = n_p[l] << 1;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= v_p;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i]   <= n_nx;
                q_reg[i]   <= q_nx;
                rem_reg[i] <= rem_nx;
                den_reg[i] <= den_p;
                tag_reg[i] <= tag_p;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign quo       = q_reg[NW-1];
    assign den_out   = den_reg[NW-1];
    assign tag_out   = tag_reg[NW-1];

endmodule
`default_nettype wire

// ===== rtl/qau_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module qau_back
    import qau_pkg::*;
#(
    parameter int DW = DATA_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_pop,
    input  wire logic [8*DW+1:0]       in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [QN-1:0][DW-1:0]      r,
    output logic [DW-2:0]              norm,
    output logic                       saturated,
    output logic                       zero_length
);

    localparam int K   = DW + 1;
    localparam int SW  = 2 * K;
    localparam int LW  = K + 1;
    localparam int NW  = DW + FB;
    localparam int PW  = 2 * DW;
    localparam int HW  = 2 * DW + 2;
    localparam int TWS = OP_BITS + 8 * DW + 1;
    localparam int TWD = OP_BITS + 4 * DW + 1 + QN;

    localparam logic signed [HW:0] HMAX = (HW+1)'({(DW-1){1'b1}});
    localparam logic signed [HW:0] HMIN = ~HMAX;
    localparam logic [HW:0]        HALF = (HW+1)'(1) << (FB - 1);
    localparam logic [LW-1:0]      LMAX = LW'({(DW-1){1'b1}});
    localparam logic [NW-1:0]      QMAX = NW'({(DW-1){1'b1}});
    localparam logic [NW-1:0]      QMIN = NW'(1) << (DW - 1);

    // clip to the signed word range; top bit flags a clip
    function automatic logic [DW:0] clip_h(input logic signed [HW:0] v);
        logic [DW:0] res;
        if (v > HMAX)
            res = {1'b1, 1'b0, {(DW-1){1'b1}}};
        else if (v < HMIN)
            res = {1'b1, 1'b1, {(DW-1){1'b0}}};
        else
            res = {1'b0, v[DW-1:0]};
        return res;
    endfunction

    logic adv;
    assign adv    = !out_valid || out_ready;
    assign in_pop = adv && in_valid;

    // stage A: products
    logic signed [DW-1:0] a_c [QN];
    logic signed [DW-1:0] b_c [QN];
    logic                 va_reg;
    op_t                  opa_reg;
    logic [QN-1:0][DW-1:0] aa_reg;
    logic signed [PW-1:0] p_reg  [16];
    logic signed [PW-1:0] sq_reg [QN];
    logic signed [PW-1:0] p_nx   [16];

    for (genvar i = 0; i < QN; i++)
    begin : g_unp
        assign a_c[i] = in_data[OP_BITS + i*DW +: DW];
        assign b_c[i] = in_data[OP_BITS + (i+QN)*DW +: DW];
    end

    // index 0 x, 1 y, 2 z, 3 w
    always_comb
    begin
        p_nx[0]  = a_c[3] * b_c[3];
        p_nx[1]  = a_c[0] * b_c[0];
        p_nx[2]  = a_c[1] * b_c[1];
        p_nx[3]  = a_c[2] * b_c[2];
        p_nx[4]  = a_c[0] * b_c[3];
        p_nx[5]  = a_c[3] * b_c[0];
        p_nx[6]  = a_c[1] * b_c[2];
        p_nx[7]  = a_c[2] * b_c[1];
        p_nx[8]  = a_c[1] * b_c[3];
        p_nx[9]  = a_c[3] * b_c[1];
        p_nx[10] = a_c[2] * b_c[0];
        p_nx[11] = a_c[0] * b_c[2];
        p_nx[12] = a_c[2] * b_c[3];
        p_nx[13] = a_c[3] * b_c[2];
        p_nx[14] = a_c[0] * b_c[1];
        p_nx[15] = a_c[1] * b_c[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (adv)
            va_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            opa_reg <= op_t'(in_data[OP_BITS-1:0]);
            for (int i = 0; i < 16; i++)
                p_reg[i] <= p_nx[i];
            for (int i = 0; i < QN; i++)
            begin
                aa_reg[i] <= a_c[i];
                sq_reg[i] <= a_c[i] * a_c[i];
            end
        end
    end

    // stage B: sums, rounding, conjugate, sum of squares
    logic signed [HW:0]  h [QN];
    logic [QN-1:0][DW:0] cl_mul, cl_conj;
    logic [SW-1:0]       s_sum;
    logic [QN-1:0][DW-1:0] rmd_nx;
    logic                satmd_nx;

    function automatic logic signed [HW:0] ext(input logic signed [PW-1:0] v);
        return (HW+1)'(v);
    endfunction

    always_comb
    begin
        h[3] = ext(p_reg[0])  - ext(p_reg[1])  - ext(p_reg[2])  - ext(p_reg[3]);
        h[0] = ext(p_reg[4])  + ext(p_reg[5])  + ext(p_reg[6])  - ext(p_reg[7]);
        h[1] = ext(p_reg[8])  + ext(p_reg[9])  + ext(p_reg[10]) - ext(p_reg[11]);
        h[2] = ext(p_reg[12]) + ext(p_reg[13]) + ext(p_reg[14]) - ext(p_reg[15]);
        for (int i = 0; i < QN; i++)
        begin
            cl_mul[i]  = clip_h((h[i] + $signed(HALF)) >>> FB);
            cl_conj[i] = clip_h(-(HW+1)'($signed(aa_reg[i])));
        end
        s_sum = SW'($unsigned(sq_reg[0])) + SW'($unsigned(sq_reg[1]))
              + SW'($unsigned(sq_reg[2])) + SW'($unsigned(sq_reg[3]));
        if ((s_sum >> 64) != '0)
            s_sum = SW'({64{1'b1}});
        if (opa_reg == OP_MUL)
        begin
            for (int i = 0; i < QN; i++)
                rmd_nx[i] = cl_mul[i][DW-1:0];
            satmd_nx = cl_mul[0][DW] | cl_mul[1][DW] | cl_mul[2][DW] | cl_mul[3][DW];
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                rmd_nx[i] = cl_conj[i][DW-1:0];
            rmd_nx[3] = aa_reg[3];
            satmd_nx  = cl_conj[0][DW] | cl_conj[1][DW] | cl_conj[2][DW];
        end
    end

    logic            vb_reg;
    logic [SW-1:0]   sb_reg;
    logic [TWS-1:0]  tagb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (adv)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg   <= s_sum;
            tagb_reg <= {satmd_nx, rmd_nx, aa_reg, opa_reg};
        end
    end

    // square root
    logic            vs;
    logic [K-1:0]    root;
    logic [K+1:0]    rem;
    logic [TWS-1:0]  tags;

    qau_sqrt #(
        .RW (K),
        .TW (TWS)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vb_reg),
        .n_in      (sb_reg),
        .tag_in    (tagb_reg),
        .out_valid (vs),
        .root      (root),
        .rem       (rem),
        .tag_out   (tags)
    );

    // stage C: rounded length and dividends
    op_t                   ops;
    logic [QN-1:0][DW-1:0] as, rmds;
    logic                  satmds;
    logic [LW-1:0]         len;
    logic [QN-1:0]         negs;
    logic [QN-1:0][NW-1:0] num_nx;

    always_comb
    begin
        {satmds, rmds, as, ops} = tags;
        len = LW'(root) + LW'((K+2)'(rem) > (K+2)'(root));
        for (int i = 0; i < QN; i++)
        begin
            logic [DW-1:0] mag;
            negs[i]   = as[i][DW-1];
            mag       = negs[i] ? -as[i] : as[i];
            num_nx[i] = (NW'(mag) << FB) + NW'(len >> 1);
        end
    end

    logic                  vc_reg;
    logic [QN-1:0][NW-1:0] numc_reg;
    logic [LW-1:0]         lenc_reg;
    logic [TWD-1:0]        tagc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (adv)
            vc_reg <= vs;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            numc_reg <= num_nx;
            lenc_reg <= len;
            tagc_reg <= {negs, satmds, rmds, ops};
        end
    end

    // division
    logic                  vd;
    logic [QN-1:0][NW-1:0] quo;
    logic [LW-1:0]         lend;
    logic [TWD-1:0]        tagd;

    qau_div #(
        .NW (NW),
        .LW (LW),
        .TW (TWD)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vc_reg),
        .num       (numc_reg),
        .den       (lenc_reg),
        .tag_in    (tagc_reg),
        .out_valid (vd),
        .quo       (quo),
        .den_out   (lend),
        .tag_out   (tagd)
    );

    // stage D: result select into the output register
    op_t                   opd;
    logic [QN-1:0][DW-1:0] rmdd;
    logic                  satmdd;
    logic [QN-1:0]         negd;
    logic                  nsat, zl;
    logic [DW-2:0]         nrm;
    logic [QN-1:0][DW-1:0] rdiv, r_nx;
    logic [QN-1:0]         dsat;
    logic [DW-2:0]         norm_nx;
    logic                  sat_nx, zl_nx;

    always_comb
    begin
        {negd, satmdd, rmdd, opd} = tagd;
        nsat = (lend > LMAX);
        nrm  = nsat ? {(DW-1){1'b1}} : lend[DW-2:0];
        zl   = (lend == '0);
        for (int i = 0; i < QN; i++)
        begin
            logic [NW-1:0] nq;
            nq = -quo[i];
            if (negd[i])
            begin
                dsat[i] = (quo[i] > QMIN);
                rdiv[i] = dsat[i] ? {1'b1, {(DW-1){1'b0}}} : nq[DW-1:0];
            end
            else
            begin
                dsat[i] = (quo[i] > QMAX);
                rdiv[i] = dsat[i] ? {1'b0, {(DW-1){1'b1}}} : quo[i][DW-1:0];
            end
        end
        r_nx    = rmdd;
        norm_nx = '0;
        sat_nx  = satmdd;
        zl_nx   = 1'b0;
        case (opd)
            OP_MUL, OP_CONJ:
            begin
                r_nx   = rmdd;
                sat_nx = satmdd;
            end
            OP_LEN:
            begin
                r_nx    = '0;
                norm_nx = nrm;
                sat_nx  = nsat;
            end
            OP_NORM:
            begin
                if (zl)
                begin
                    r_nx   = '0;
                    sat_nx = 1'b0;
                    zl_nx  = 1'b1;
                end
                else
                begin
                    r_nx    = rdiv;
                    norm_nx = nrm;
                    sat_nx  = nsat | (|dsat);
                end
            end
            default:
            begin
                r_nx   = rmdd;
                sat_nx = satmdd;
            end
        endcase
    end

    logic                  out_v_reg;
    logic [QN-1:0][DW-1:0] r_reg;
    logic [DW-2:0]         norm_reg;
    logic                  sat_reg, zl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= vd;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg    <= r_nx;
            norm_reg <= norm_nx;
            sat_reg  <= sat_nx;
            zl_reg   <= zl_nx;
        end
    end

    assign out_valid   = out_v_reg;
    assign r           = r_reg;
    assign norm        = norm_reg;
    assign saturated   = sat_reg;
    assign zero_length = zl_reg;

    `QAU_ASSERT(a_zl_clean, out_v_reg && zl_reg |-> r_reg == '0 && norm_reg == '0 && !sat_reg, "zero length result not cleared")
    `QAU_ASSERT(a_hold, out_v_reg && !out_ready |=> out_v_reg && $stable(r_reg), "result dropped while stalled")
    `QAU_ASSERT(a_src, $rose(out_v_reg) |-> $past(vd), "result without a finished division stage")

endmodule
`default_nettype wire

// ===== rtl/quaternion_arith_unit.sv =====
`default_nettype none
// Quaternion unit, signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS: each item gives one result.
// Fully pipelined: one item per cycle sustained while the output is taken. Every item
// passes through the bit-per-stage square root (DATA_WIDTH+1 stages) and the
// bit-per-stage divider (DATA_WIDTH+FRAC_BITS stages), whatever its operation. A
// two-item input queue decouples s_axis from the pipeline; the pipeline stalls as a
// whole when the output item is not taken.
module quaternion_arith_unit
    import qau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w
    input  wire logic [8*DATA_WIDTH-1:0]        s_axis_tdata,
    // op
    input  wire logic [OP_BITS-1:0]             s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // r_x, r_y, r_z, r_w, norm, saturated, zero_length, zero fill
    output logic [((5*DATA_WIDTH+8)/8)*8-1:0]   m_axis_tdata
);

    localparam int OB = ((5 * DATA_WIDTH + 8) / 8) * 8;

    logic                          q_valid, q_pop;
    logic [8*DATA_WIDTH+1:0]       q_data;
    logic [QN-1:0][DATA_WIDTH-1:0] r;
    logic [DATA_WIDTH-2:0]         norm;
    logic                          saturated, zero_length;

    qau_front #(
        .DW (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   ({s_axis_tdata, s_axis_tuser}),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_data  (q_data)
    );

    qau_back #(
        .DW (DATA_WIDTH),
        .FB (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .in_pop      (q_pop),
        .in_data     (q_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .r           (r),
        .norm        (norm),
        .saturated   (saturated),
        .zero_length (zero_length)
    );

    assign m_axis_tdata = OB'({zero_length, saturated, norm, r[3], r[2], r[1], r[0]});

endmodule
`default_nettype wire
